// ----- hdl/lpfs_pkg.sv -----
`timescale 1ns / 1ps

package lpfs_pkg;

  // default width of the value that is factored
  localparam int unsigned VALUE_WIDTH_DEF = 64;

  // step counter of the sequencer
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // program steps
  localparam step_t ST_WAIT     = 4'd0;
  localparam step_t ST_SMALL    = 4'd1;
  localparam step_t ST_SQUARE   = 4'd2;
  localparam step_t ST_TEST     = 4'd3;
  localparam step_t ST_DIV      = 4'd4;
  localparam step_t ST_DIV_WAIT = 4'd5;
  localparam step_t ST_DIV_TEST = 4'd6;
  localparam step_t ST_TAKE     = 4'd7;
  localparam step_t ST_NEXT     = 4'd8;
  localparam step_t ST_TAIL     = 4'd9;
  localparam step_t ST_EMIT     = 4'd10;
  localparam step_t ST_BACK     = 4'd11;

  // datapath operation of one step
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQUARE,
    OP_DIV_START,
    OP_TAKE,
    OP_NEXT_D,
    OP_TAIL,
    OP_EMIT
  } op_e;

  // jump condition of one step
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SMALL,
    C_SQ_GT_REM,
    C_DIV_BUSY,
    C_REM_NZ,
    C_OUT_BUSY
  } cond_e;

  // one control word
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic rem_nz;
  } div_stat_t;

  // control store
  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t w;
    unique case (pc)
      ST_WAIT:     w = '{op: OP_LOAD,      cond: C_NO_INPUT,  target: ST_WAIT};
      ST_SMALL:    w = '{op: OP_NOP,       cond: C_SMALL,     target: ST_EMIT};
      ST_SQUARE:   w = '{op: OP_SQUARE,    cond: C_NEVER,     target: ST_WAIT};
      ST_TEST:     w = '{op: OP_NOP,       cond: C_SQ_GT_REM, target: ST_TAIL};
      ST_DIV:      w = '{op: OP_DIV_START, cond: C_NEVER,     target: ST_WAIT};
      ST_DIV_WAIT: w = '{op: OP_NOP,       cond: C_DIV_BUSY,  target: ST_DIV_WAIT};
      ST_DIV_TEST: w = '{op: OP_NOP,       cond: C_REM_NZ,    target: ST_NEXT};
      ST_TAKE:     w = '{op: OP_TAKE,      cond: C_ALWAYS,    target: ST_DIV};
      ST_NEXT:     w = '{op: OP_NEXT_D,    cond: C_ALWAYS,    target: ST_SQUARE};
      ST_TAIL:     w = '{op: OP_TAIL,      cond: C_NEVER,     target: ST_WAIT};
      ST_EMIT:     w = '{op: OP_EMIT,      cond: C_OUT_BUSY,  target: ST_EMIT};
      ST_BACK:     w = '{op: OP_NOP,       cond: C_ALWAYS,    target: ST_WAIT};
      default:     w = '{op: OP_NOP,       cond: C_ALWAYS,    target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/lpfs_div.sv -----
`timescale 1ns / 1ps

module lpfs_div #(
  parameter int unsigned NUM_W = 63,
  parameter int unsigned DEN_W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic [NUM_W-1:0]     quot_o,
  output lpfs_pkg::div_stat_t  stat_o
);
  import lpfs_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] r_q, r_d;
  logic [NUM_W-1:0] q_q, q_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {r_q, q_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_comb begin
    r_d    = r_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      r_d    = '0;
      q_d    = num_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_d   = {q_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
  end

  assign quot_o        = q_q;
  assign stat_o.busy   = busy_q;
  assign stat_o.rem_nz = r_q != '0;

endmodule

// ----- hdl/largest_prime_factor_sum_core.sv -----
`timescale 1ns / 1ps

// Largest prime factor of a signed value, with a running batch sum.
// Input stream: s_axis_tdata carries the value, s_axis_tlast marks the last
// value of a batch. Output stream: one transfer per input, carrying the
// factor, the running sum including it, and tlast as the batch-done flag.
// The sum wraps in 64 bits and is cleared once a result with tlast set is loaded into the output register.
// Values at or below one give max(0, value) without any trial division.
// Otherwise the value is trial-divided by 2, 3, 5, 7, ... until the divisor
// squared exceeds the cofactor. Each trial divisor and every factor divided
// out costs one run of the bit-serial divider, so an item needs about s / 2 + 1
// trial divisors, s being the larger of the second-largest prime factor and
// the square root of the largest one (up to about 1.5e9 divisors for 64-bit
// primes).
// One item is worked on at a time; the next input is taken once the result
// has moved to the output register, so it may wait while the receiver stalls.
// Reset clears the sequencer, the output valid and the batch sum.

module largest_prime_factor_sum_core #(
  parameter int unsigned VALUE_WIDTH = lpfs_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // value
  input  logic          s_axis_tlast,   // end_of_batch
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // largest_factor[62:0], batch_sum[126:63], zero pad
  output logic          m_axis_tlast    // batch_done
);
  import lpfs_pkg::*;

  localparam int unsigned NUM_W = VALUE_WIDTH - 1;
  localparam int unsigned DEN_W = (VALUE_WIDTH + 1) / 2;
  localparam int unsigned SQ_W  = 2 * DEN_W;

  step_t             pc_q, pc_d;
  ctrl_t             cw;
  logic              jump;

  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  best_q, best_d;
  logic [DEN_W-1:0]  dv_q, dv_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic              small_q, small_d;
  logic              last_q, last_d;
  logic [63:0]       sum_q, sum_d;

  logic              out_valid_q, out_valid_d;
  logic [62:0]       out_factor_q;
  logic [63:0]       out_sum_q;
  logic              out_last_q;

  logic              out_free;
  logic              emit;
  logic              div_start;
  logic [NUM_W-1:0]  quot;
  div_stat_t         div_stat;

  logic              in_neg;
  logic [NUM_W-1:0]  in_mag;
  logic              in_small;
  logic [63:0]       sum_next;

  // control word of the current step
  assign cw = ucode(pc_q);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = cw.op == OP_LOAD;
  assign emit          = (cw.op == OP_EMIT) && out_free;
  assign div_start     = cw.op == OP_DIV_START;

  // jump condition
  always_comb begin
    unique case (cw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_INPUT:  jump = !s_axis_tvalid;
      C_SMALL:     jump = small_q;
      C_SQ_GT_REM: jump = sq_q > SQ_W'(rem_q);
      C_DIV_BUSY:  jump = div_stat.busy;
      C_REM_NZ:    jump = div_stat.rem_nz;
      C_OUT_BUSY:  jump = !out_free;
      default:     jump = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    pc_d = jump ? cw.target : pc_q + step_t'(1);
  end

  // value taken from the low bits, sign at the top
  assign in_neg   = s_axis_tdata[VALUE_WIDTH-1];
  assign in_mag   = s_axis_tdata[NUM_W-1:0];
  assign in_small = in_neg || (in_mag <= NUM_W'(1));
  assign sum_next = sum_q + 64'(best_q);

  // datapath operations
  always_comb begin
    rem_d   = rem_q;
    best_d  = best_q;
    dv_d    = dv_q;
    sq_d    = sq_q;
    small_d = small_q;
    last_d  = last_q;
    sum_d   = sum_q;
    unique case (cw.op)
      OP_LOAD: begin
        rem_d   = in_mag;
        best_d  = in_small && !in_neg ? in_mag : '0;
        dv_d    = DEN_W'(2);
        small_d = in_small;
        last_d  = s_axis_tlast;
      end
      OP_SQUARE: begin
        sq_d = SQ_W'(dv_q) * SQ_W'(dv_q);
      end
      OP_TAKE: begin
        best_d = NUM_W'(dv_q);
        rem_d  = quot;
      end
      OP_NEXT_D: begin
        dv_d = (dv_q == DEN_W'(2)) ? DEN_W'(3) : dv_q + DEN_W'(2);
      end
      OP_TAIL: begin
        if (rem_q > NUM_W'(1) && rem_q > best_q) begin
          best_d = rem_q;
        end
      end
      OP_EMIT: begin
        if (emit) begin
          sum_d = last_q ? 64'd0 : sum_next;
        end
      end
      OP_NOP, OP_DIV_START: begin
      end
      default: begin
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state and batch sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ST_WAIT;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    best_q  <= best_d;
    dv_q    <= dv_d;
    sq_q    <= sq_d;
    small_q <= small_d;
    last_q  <= last_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_factor_q <= 63'(best_q);
      out_sum_q    <= sum_next;
      out_last_q   <= last_q;
    end
  end

  lpfs_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rem_q),
    .den_i   (dv_q),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_sum_q, out_factor_q};
  assign m_axis_tlast  = out_last_q;

endmodule
